// File: design/kfi_pkg.sv
`timescale 1ns / 1ps
package kfi_pkg;
    localparam int POSE_W = 32;
    localparam int ACC_W  = 48;
    localparam int DIFF_W = 33;
    localparam int MAG_W  = 49;
    localparam int DIV_W  = 16;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_TOGGLE  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    localparam logic signed [ACC_W-1:0] POSE_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] POSE_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DIV_W-1:0] STEPS_RESET = 16'd1000;
endpackage

// File: design/kfi_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, signed result saturated to 48 bits
module kfi_divider
    import kfi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_diff,
    input  logic [DIV_W-1:0]         i_divisor,
    output logic                     o_done,
    output logic signed [ACC_W-1:0]  o_quot
);
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]  r_num;
    logic [MAG_W-1:0]  r_quo;
    logic [DIV_W:0]    r_rem;
    logic [DIV_W-1:0]  r_den;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    n_trial;
    logic [DIV_W:0]    n_shift;
    logic [DIFF_W-1:0] n_abs;

    assign n_abs   = i_diff[DIFF_W-1] ? (~i_diff + 1'b1) : i_diff;
    assign n_shift = {r_rem[DIV_W-1:0], r_num[MAG_W-1]};
    assign n_trial = n_shift - {1'b0, r_den};

    // iterate over the 49 numerator bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
                r_num  <= {n_abs[MAG_W-17:0], 16'd0};
                r_quo  <= '0;
                r_rem  <= '0;
                r_den  <= (i_divisor == '0) ? DIV_W'(1) : i_divisor;
                r_neg  <= i_diff[DIFF_W-1];
            end else if (r_busy) begin
                r_num <= {r_num[MAG_W-2:0], 1'b0};
                if (!n_trial[DIV_W]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign and saturate
    always_comb begin
        if (r_neg) begin
            if (r_quo > {1'b0, POSE_MIN}) o_quot = POSE_MIN;
            else o_quot = ACC_W'(~r_quo + 1'b1);
        end else begin
            if (r_quo > {1'b0, POSE_MAX}) o_quot = POSE_MAX;
            else o_quot = ACC_W'(r_quo);
        end
    end
    assign o_done = r_done;
endmodule

// File: design/keyframe_linear_interpolator.sv
`timescale 1ns / 1ps
// channel | signals                        | direction
// request | i_valid/o_ready, i_operation.. | in
// result  | o_valid/i_ready, o_is_playing..| out
// config  | i_cfg_we, i_cfg_data           | in
// one request at a time; tick and capture step through the channels, while clear, toggle stop
// and a tick that stops or does nothing go straight to the result; toggle start and a segment
// change run each channel through the shared serial divider, and the single-port key store
// is written one channel per cycle on capture and read one channel per divide on playback.
// synchronous active-low reset clears control and live pose; key store is not reset.
// o_ready stays low until the result is taken.
module keyframe_linear_interpolator
    import kfi_pkg::*;
#(
    parameter int MAX_KEYFRAMES = 8,
    parameter int POSE_CHANNELS = 11
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic i_valid,
    output logic o_ready,
    input  logic [1:0] i_operation,
    input  logic signed [31:0] i_in_pos_x,
    input  logic signed [31:0] i_in_pos_y,
    input  logic signed [31:0] i_in_pos_z,
    input  logic signed [31:0] i_in_yaw,
    input  logic signed [31:0] i_in_head_angle,
    input  logic signed [31:0] i_in_pitch_angle,
    input  logic signed [31:0] i_in_tail_angle,
    input  logic signed [31:0] i_in_front_left_angle,
    input  logic signed [31:0] i_in_front_right_angle,
    input  logic signed [31:0] i_in_rear_left_angle,
    input  logic signed [31:0] i_in_rear_right_angle,
    output logic o_valid,
    input  logic i_ready,
    output logic o_is_playing,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_out_yaw,
    output logic signed [31:0] o_out_head_angle,
    output logic signed [31:0] o_out_pitch_angle,
    output logic signed [31:0] o_out_tail_angle,
    output logic signed [31:0] o_out_front_left_angle,
    output logic signed [31:0] o_out_front_right_angle,
    output logic signed [31:0] o_out_rear_left_angle,
    output logic signed [31:0] o_out_rear_right_angle
);
    localparam int DEPTH = MAX_KEYFRAMES * POSE_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(MAX_KEYFRAMES + 1);
    localparam int SW    = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CW    = (POSE_CHANNELS > 1) ? $clog2(POSE_CHANNELS) : 1;
    localparam int NCH   = 11;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_ADD   = 8'b00000010,
        S_RDA   = 8'b00000100,
        S_RDB   = 8'b00001000,
        S_DIV   = 8'b00010000,
        S_WAIT  = 8'b00100000,
        S_CAP   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    logic [DIV_W-1:0] r_steps;
    logic [POSE_W-1:0] r_mem [DEPTH];
    logic [POSE_W-1:0] r_rd;
    logic signed [ACC_W-1:0] r_inc  [POSE_CHANNELS];
    logic signed [ACC_W-1:0] r_pose [POSE_CHANNELS];
    logic [POSE_W-1:0] r_cap [POSE_CHANNELS];
    logic signed [POSE_W-1:0] r_a;
    logic [FW-1:0] r_frames;
    logic [SW-1:0] r_seg;
    logic [DIV_W-1:0] r_stepcnt;
    logic r_play;
    logic [CW-1:0] r_ch;
    logic r_room;
    logic r_first;
    logic [AW-1:0] r_addr;
    logic [POSE_W-1:0] in_pose [NCH];
    logic [DIV_W-1:0] eff_steps;
    logic div_start, div_done;
    logic signed [ACC_W-1:0] div_q;
    logic signed [ACC_W:0] sum;
    logic signed [DIFF_W-1:0] diff;
    logic last_ch;

    assign in_pose = '{i_in_pos_x, i_in_pos_y, i_in_pos_z, i_in_yaw, i_in_head_angle,
        i_in_pitch_angle, i_in_tail_angle, i_in_front_left_angle, i_in_front_right_angle,
        i_in_rear_left_angle, i_in_rear_right_angle};
    assign eff_steps = (r_steps == '0) ? DIV_W'(1) : r_steps;
    assign last_ch   = (r_ch == CW'(POSE_CHANNELS - 1));
    assign sum  = {r_pose[r_ch][ACC_W-1], r_pose[r_ch]} + {r_inc[r_ch][ACC_W-1], r_inc[r_ch]};
    assign diff = {r_rd[POSE_W-1], r_rd} - {r_a[POSE_W-1], r_a};
    assign div_start = (r_state == S_DIV);

    kfi_divider u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_diff(diff),
        .i_divisor(eff_steps), .o_done(div_done), .o_quot(div_q)
    );

    // key store, one port
    always_ff @(posedge i_clk) begin
        if (r_state == S_CAP && r_room) r_mem[r_addr] <= r_cap[r_ch];
        r_rd <= r_mem[r_addr];
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_steps <= STEPS_RESET;
        else if (i_cfg_we) r_steps <= i_cfg_data;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_frames <= '0; r_seg <= '0; r_stepcnt <= '0; r_play <= 1'b0;
            r_ch <= '0; r_addr <= '0; r_room <= 1'b0; r_first <= 1'b0;
            for (int c = 0; c < POSE_CHANNELS; c++) begin
                r_inc[c] <= '0; r_pose[c] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ch <= '0;
                        unique case (t_op'(i_operation))
                            OP_TICK: begin
                                if (!r_play) r_state <= S_OUT;
                                else if (r_stepcnt >= eff_steps) begin
                                    if (32'(r_seg) + 3 > 32'(r_frames)) begin
                                        r_seg <= '0; r_play <= 1'b0; r_state <= S_OUT;
                                    end else begin
                                        r_seg <= r_seg + 1'b1; r_stepcnt <= '0;
                                        r_first <= 1'b0;
                                        r_addr <= AW'((32'(r_seg) + 1) * POSE_CHANNELS);
                                        r_state <= S_RDA;
                                    end
                                end else begin
                                    r_stepcnt <= r_stepcnt + 1'b1; r_state <= S_ADD;
                                end
                            end
                            OP_CAPTURE: begin
                                r_room <= (32'(r_frames) < MAX_KEYFRAMES);
                                r_addr <= AW'(32'(r_frames) * POSE_CHANNELS);
                                for (int c = 0; c < POSE_CHANNELS; c++) r_cap[c] <= in_pose[c];
                                r_state <= S_CAP;
                            end
                            OP_TOGGLE: begin
                                if (!r_play && r_frames > FW'(1)) begin
                                    r_seg <= '0; r_stepcnt <= '0; r_play <= 1'b1;
                                    r_first <= 1'b1; r_addr <= '0; r_state <= S_RDA;
                                end else begin
                                    r_play <= 1'b0; r_state <= S_OUT;
                                end
                            end
                            OP_CLEAR: begin
                                r_frames <= '0; r_seg <= '0; r_stepcnt <= '0; r_play <= 1'b0;
                                for (int c = 0; c < POSE_CHANNELS; c++) begin
                                    r_inc[c] <= '0; r_pose[c] <= '0;
                                end
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                // saturating add, one channel per cycle
                S_ADD: begin
                    if (sum > $signed({POSE_MAX[ACC_W-1], POSE_MAX}))
                        r_pose[r_ch] <= POSE_MAX;
                    else if (sum < $signed({POSE_MIN[ACC_W-1], POSE_MIN}))
                        r_pose[r_ch] <= POSE_MIN;
                    else r_pose[r_ch] <= ACC_W'(sum);
                    r_ch <= r_ch + 1'b1;
                    if (last_ch) r_state <= S_OUT;
                end
                S_CAP: begin
                    r_pose[r_ch] <= {r_cap[r_ch], 16'd0};
                    r_addr <= r_addr + 1'b1;
                    r_ch <= r_ch + 1'b1;
                    if (last_ch) begin
                        if (r_room) r_frames <= r_frames + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                // read keyframe a, then b
                S_RDA: begin
                    r_addr <= r_addr + AW'(POSE_CHANNELS);
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_a <= r_rd;
                    if (r_first) r_pose[r_ch] <= {r_rd, 16'd0};
                    r_state <= S_DIV;
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (div_done) begin
                        r_inc[r_ch] <= div_q;
                        r_ch <= r_ch + 1'b1;
                        if (last_ch) r_state <= S_OUT;
                        else begin
                            r_addr <= r_addr - AW'(POSE_CHANNELS) + 1'b1;
                            r_state <= S_RDA;
                        end
                    end
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_is_playing = r_play;

    logic [31:0] outs [NCH];
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            outs[c] = '0;
            if (c < POSE_CHANNELS) outs[c] = r_pose[c][ACC_W-1:16];
        end
    end
    assign o_out_pos_x = outs[0];
    assign o_out_pos_y = outs[1];
    assign o_out_pos_z = outs[2];
    assign o_out_yaw = outs[3];
    assign o_out_head_angle = outs[4];
    assign o_out_pitch_angle = outs[5];
    assign o_out_tail_angle = outs[6];
    assign o_out_front_left_angle = outs[7];
    assign o_out_front_right_angle = outs[8];
    assign o_out_rear_left_angle = outs[9];
    assign o_out_rear_right_angle = outs[10];
endmodule
